// File: hdl/dh_link_transform_assert.svh
// ----------------------------------------------------------------------------
// dh_link_transform_assert
// Assertion macros used by dh_link_transform. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DH_LINK_TRANSFORM_ASSERT_SVH
`define DH_LINK_TRANSFORM_ASSERT_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define DLT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dh_link_transform: assertion failed");
// checked on every edge, reset included
`define DLT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("dh_link_transform: assertion failed");
`else
`define DLT_ASSERT(lbl, clk, rst_n, prop)
`define DLT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: hdl/dhlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhlt_pkg
// Types and fixed constants of the DH link transform: field widths, item
// structs and the sine polynomial coefficients.
// ----------------------------------------------------------------------------
package dhlt_pkg;

    localparam int ANGLE_BITS  = 16;
    localparam int LENGTH_BITS = 20;
    localparam int TRIG_BITS   = 16;

    // sine polynomial, Q16
    localparam int SIN_A   = 102944;
    localparam int SIN_B   = 42048;
    localparam int SIN_C   = 4640;
    localparam int ONE_Q14 = 16384;

    // product rounding at bit 14
    localparam int Q14_FRAC = 14;
    localparam int HALF_Q14 = 8192;

    // pipeline depths
    localparam int SIN_LATENCY = 6;
    localparam int MAT_LATENCY = 2;

    typedef logic        [ANGLE_BITS-1:0]  t_angle;
    typedef logic signed [LENGTH_BITS-1:0] t_length;
    typedef logic signed [TRIG_BITS-1:0]   t_trig;

    localparam t_angle QUARTER_TURN = t_angle'(1) << (ANGLE_BITS - 2);

    typedef struct packed {
        t_length link_offset;
        t_length link_length;
        t_angle  theta_offset;
        t_angle  twist_angle;
        t_angle  joint_angle;
    } t_in_item;

    typedef struct packed {
        t_trig   r00;
        t_trig   r10;
        t_trig   r01;
        t_trig   r11;
        t_trig   r21;
        t_trig   r02;
        t_trig   r12;
        t_trig   r22;
        t_length tx;
        t_length ty;
        t_length tz;
    } t_out_item;

endpackage

// File: hdl/dhlt_sin_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhlt_sin_lane
// Six-stage sine of a binary angle: quadrant fold, then the odd polynomial
// u*(A - u2*(B - C*u2)) with one multiplier per stage, round and clamp.
// ----------------------------------------------------------------------------
module dhlt_sin_lane (
    input  logic            i_clk,
    input  logic            i_en,
    input  dhlt_pkg::t_angle i_angle,
    output dhlt_pkg::t_trig  o_sin
);
    import dhlt_pkg::*;

    localparam int FRAC_BITS = ANGLE_BITS - 2;
    localparam int Z_BITS    = 16;
    localparam int U_BITS    = Z_BITS + 1;
    localparam logic [U_BITS-1:0] U_ONE = U_BITS'(1) << Z_BITS;
    localparam logic [2*U_BITS:0] ROUND_Q18 = (2*U_BITS+1)'(1) << 17;

    logic [FRAC_BITS-1:0] frac;
    logic [Z_BITS-1:0]    z;
    logic [1:0]           n_q1;
    logic [U_BITS-1:0]    n_u1;

    // stage registers
    logic [1:0]          r_q1, r_q2, r_q3, r_q4, r_q5;
    logic [U_BITS-1:0]   r_u1, r_u2, r_u3, r_u4;
    logic [U_BITS-1:0]   r_sq2, r_sq3;
    logic [15:0]         r_t3;
    logic [U_BITS-1:0]   r_t4;
    logic [2*U_BITS-1:0] r_p5;
    t_trig               r_s6;

    logic [2*U_BITS-1:0] sq_prod;
    logic [29:0]         c_prod;
    logic [32:0]         b_prod;
    logic [2*U_BITS:0]   rnd_sum;
    logic [U_BITS-1:0]   mag;
    logic [U_BITS-1:0]   clamped;
    t_trig               n_s6;

    assign frac = i_angle[FRAC_BITS-1:0];

    // scale the in-quadrant position to a Q16 fraction of a quarter turn
    generate
        if (ANGLE_BITS <= 18) begin : g_scale_up
            assign z = Z_BITS'(frac) << (18 - ANGLE_BITS);
        end else begin : g_scale_down
            assign z = frac[FRAC_BITS-1 -: Z_BITS];
        end
    endgenerate

    assign n_q1 = i_angle[ANGLE_BITS-1 -: 2];
    // mirror inside odd quadrants
    assign n_u1 = n_q1[0] ? (U_ONE - {1'b0, z}) : {1'b0, z};

    assign sq_prod = (2*U_BITS)'(r_u1) * (2*U_BITS)'(r_u1);
    assign c_prod  = 30'(SIN_C) * 30'(r_sq2);
    assign b_prod  = 33'(r_t3) * 33'(r_sq3);

    assign rnd_sum = (2*U_BITS+1)'(r_p5) + ROUND_Q18;
    assign mag     = rnd_sum[2*U_BITS -: U_BITS];
    assign clamped = (mag > U_BITS'(ONE_Q14)) ? U_BITS'(ONE_Q14) : mag;
    assign n_s6    = r_q5[1] ? -t_trig'(clamped) : t_trig'(clamped);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1  <= n_q1;
            r_u1  <= n_u1;

            r_q2  <= r_q1;
            r_u2  <= r_u1;
            r_sq2 <= sq_prod[32:16];

            r_q3  <= r_q2;
            r_u3  <= r_u2;
            r_sq3 <= r_sq2;
            r_t3  <= 16'(SIN_B) - {2'b00, c_prod[29:16]};

            r_q4  <= r_q3;
            r_u4  <= r_u3;
            r_t4  <= U_BITS'(SIN_A) - b_prod[32:16];

            r_q5  <= r_q4;
            r_p5  <= (2*U_BITS)'(r_t4) * (2*U_BITS)'(r_u4);

            r_s6  <= n_s6;
        end
    end

    assign o_sin = r_s6;

endmodule

// File: hdl/dhlt_mat_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhlt_mat_stage
// Builds the rotation and translation entries from the four sines and
// cosines: one stage of products, one stage of rounding and saturation.
// ----------------------------------------------------------------------------
module dhlt_mat_stage (
    input  logic                i_clk,
    input  logic                i_en,
    input  dhlt_pkg::t_trig     i_st,
    input  dhlt_pkg::t_trig     i_ct,
    input  dhlt_pkg::t_trig     i_sa,
    input  dhlt_pkg::t_trig     i_ca,
    input  dhlt_pkg::t_length   i_len,
    input  dhlt_pkg::t_length   i_off,
    output dhlt_pkg::t_out_item o_item
);
    import dhlt_pkg::*;

    localparam int PROD_BITS  = 2 * TRIG_BITS;
    localparam int LPROD_BITS = LENGTH_BITS + TRIG_BITS;
    localparam int LRND_BITS  = LPROD_BITS - Q14_FRAC;

    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic signed [LPROD_BITS-1:0] t_lprod;
    typedef logic signed [LRND_BITS-1:0]  t_lrnd;

    localparam t_lrnd LEN_HI = {(LRND_BITS - LENGTH_BITS + 1)'(0), {(LENGTH_BITS-1){1'b1}}};
    localparam t_lrnd LEN_LO = ~LEN_HI;

    function automatic t_trig rnd_trig(input t_prod p);
        t_prod v;
        v = p + t_prod'(HALF_Q14);
        return t_trig'(v >>> Q14_FRAC);
    endfunction

    function automatic t_length rnd_len(input t_lprod p);
        t_lprod v;
        t_lrnd  s;
        v = p + t_lprod'(HALF_Q14);
        s = t_lrnd'(v >>> Q14_FRAC);
        if (s > LEN_HI) begin
            s = LEN_HI;
        end else if (s < LEN_LO) begin
            s = LEN_LO;
        end
        return t_length'(s);
    endfunction

    t_prod     r_p01, r_p11, r_p02, r_p12;
    t_lprod    r_ptx, r_pty;
    t_trig     r_st, r_ct, r_sa, r_ca;
    t_length   r_off;
    t_out_item r_item;
    t_out_item n_item;

    always_comb begin
        n_item.r00 = r_ct;
        n_item.r10 = r_st;
        // minus signs go in before rounding
        n_item.r01 = rnd_trig(-r_p01);
        n_item.r11 = rnd_trig(r_p11);
        n_item.r21 = r_sa;
        n_item.r02 = rnd_trig(r_p02);
        n_item.r12 = rnd_trig(-r_p12);
        n_item.r22 = r_ca;
        n_item.tx  = rnd_len(r_ptx);
        n_item.ty  = rnd_len(r_pty);
        n_item.tz  = r_off;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p01  <= t_prod'(i_st) * t_prod'(i_ca);
            r_p11  <= t_prod'(i_ct) * t_prod'(i_ca);
            r_p02  <= t_prod'(i_st) * t_prod'(i_sa);
            r_p12  <= t_prod'(i_ct) * t_prod'(i_sa);
            r_ptx  <= t_lprod'(i_len) * t_lprod'(i_ct);
            r_pty  <= t_lprod'(i_len) * t_lprod'(i_st);
            r_st   <= i_st;
            r_ct   <= i_ct;
            r_sa   <= i_sa;
            r_ca   <= i_ca;
            r_off  <= i_off;
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// File: hdl/dh_link_transform.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle while no held result stalls the pipe; no stage shares a multiplier.
// A stalled result holds the whole pipeline in place; bubbles are not squeezed.
// Reset (synchronous, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// dh_link_transform
// Denavit-Hartenberg link transform: input register, four sine lanes for
// theta and alpha, product and rounding stages, output register.
// ----------------------------------------------------------------------------
module dh_link_transform (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  dhlt_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output dhlt_pkg::t_out_item o_item
);
    import dhlt_pkg::*;

`include "dh_link_transform_assert.svh"

    localparam int NSTAGE = 1 + SIN_LATENCY + MAT_LATENCY;

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_vld;
    t_in_item          r_in;
    t_length           r_len_dly [SIN_LATENCY];
    t_length           r_off_dly [SIN_LATENCY];

    logic   en;
    t_angle theta;
    t_angle theta_c;
    t_angle alpha_c;
    t_trig  st, ct, sa, ca;

    // the whole pipe moves unless a finished item is held at the output
    assign en      = !(r_vld[NSTAGE-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NSTAGE-1];
    assign n_vld   = {r_vld[NSTAGE-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in         <= i_item;
            r_len_dly[0] <= r_in.link_length;
            r_off_dly[0] <= r_in.link_offset;
            for (int k = 1; k < SIN_LATENCY; k++) begin
                r_len_dly[k] <= r_len_dly[k-1];
                r_off_dly[k] <= r_off_dly[k-1];
            end
        end
    end

    // joint angle wraps modulo a full turn
    assign theta   = r_in.theta_offset + r_in.joint_angle;
    assign theta_c = theta + QUARTER_TURN;
    assign alpha_c = r_in.twist_angle + QUARTER_TURN;

    dhlt_sin_lane u_sin_theta (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (theta),
        .o_sin   (st)
    );

    dhlt_sin_lane u_cos_theta (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (theta_c),
        .o_sin   (ct)
    );

    dhlt_sin_lane u_sin_alpha (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_in.twist_angle),
        .o_sin   (sa)
    );

    dhlt_sin_lane u_cos_alpha (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (alpha_c),
        .o_sin   (ca)
    );

    dhlt_mat_stage u_mat (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_st   (st),
        .i_ct   (ct),
        .i_sa   (sa),
        .i_ca   (ca),
        .i_len  (r_len_dly[SIN_LATENCY-1]),
        .i_off  (r_off_dly[SIN_LATENCY-1]),
        .o_item (o_item)
    );

    // back-pressure only comes from a held result
    `DLT_ASSERT(a_stall_needs_result, i_clk, i_rst_n, o_stall |-> o_valid)
    // an accepted item enters the first stage
    `DLT_ASSERT(a_accept_enters, i_clk, i_rst_n, (i_valid && !o_stall) |=> r_vld[0])
    // nothing moves while the output is held
    `DLT_ASSERT(a_hold_freezes, i_clk, i_rst_n, o_stall |=> $stable(r_vld))
    // cosine entries stay within plus and minus one
    `DLT_ASSERT(a_cos_range, i_clk, i_rst_n, o_valid |-> (o_item.r00 <= t_trig'(ONE_Q14) && o_item.r00 >= -t_trig'(ONE_Q14) && o_item.r22 <= t_trig'(ONE_Q14) && o_item.r22 >= -t_trig'(ONE_Q14)))

endmodule
